// ----- design/nds_pkg.sv -----
package nds_pkg;

  localparam int DIM_BITS  = 24;
  // Trial divisor i never passes 2^ceil(DIM_BITS/2).
  localparam int IDX_BITS  = (DIM_BITS + 1) / 2 + 1;
  // Running square of i, one step past the loop bound.
  localparam int SQ_BITS   = DIM_BITS + 2;
  localparam int PROD_BITS = 2 * DIM_BITS;
  localparam int CNT_BITS  = $clog2(DIM_BITS + 1);

  typedef logic [DIM_BITS-1:0]  dim_t;
  typedef logic [IDX_BITS-1:0]  idx_t;
  typedef logic [SQ_BITS-1:0]   sq_t;
  typedef logic [PROD_BITS-1:0] prod_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_WAIT_DIV,
    ST_CMP_I,
    ST_WAIT_I,
    ST_CMP_Q,
    ST_WAIT_Q,
    ST_FINISH
  } seq_state_t;

  typedef enum logic [1:0] {
    CMP_IDLE,
    CMP_LHS,
    CMP_RHS,
    CMP_DONE
  } cmp_phase_t;

  typedef struct packed {
    logic start;
    dim_t dividend;
    idx_t divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    dim_t quot;
    logic rem_zero;
  } div_rsp_t;

  typedef struct packed {
    logic start;
    dim_t cand;
    dim_t best;
    dim_t target;
  } cmp_req_t;

  typedef struct packed {
    logic done;
    logic closer;
  } cmp_rsp_t;

endpackage

// ----- design/nds_in_if.sv -----
interface nds_in_if;
  logic                 valid;
  logic                 ready;
  logic [nds_pkg::DIM_BITS-1:0] dim_size;
  logic [nds_pkg::DIM_BITS-1:0] target_size;

  modport source(output valid, output dim_size, output target_size, input ready);
  modport sink(input valid, input dim_size, input target_size, output ready);
endinterface

// ----- design/nds_out_if.sv -----
interface nds_out_if;
  logic                 valid;
  logic                 ready;
  logic [nds_pkg::DIM_BITS-1:0] best_factor;

  modport source(output valid, output best_factor, input ready);
  modport sink(input valid, input best_factor, output ready);
endinterface

// ----- design/nearest_divisor_log_ratio.sv -----
// Nearest divisor by ratio: for each transfer of (dim_size, target_size) the block
// returns the divisor of dim_size whose ratio max/min against target_size is
// smallest, dim_size itself tried first, then i and dim_size/i for every i with
// i*i <= dim_size; the earliest candidate wins a tie. An item's run time is set by
// the serial restoring divider, one quotient bit a cycle, and by the ratio compare,
// which forms its two cross products on one multiplier. in_chan.ready is high only
// between items; a finished result sits in the output register, so the next item
// can be taken while the result still waits.
module nearest_divisor_log_ratio (
  input  logic       clk,
  input  logic       rst_n,
  nds_in_if.sink     in_chan,
  nds_out_if.source  out_chan
);

  nds_pkg::seq_state_t state_r;
  nds_pkg::seq_state_t state_nxt;
  nds_pkg::dim_t       size_r;
  nds_pkg::dim_t       target_r;
  nds_pkg::dim_t       best_r;
  nds_pkg::idx_t       i_r;
  nds_pkg::sq_t        isq_r;
  logic                out_valid_r;
  nds_pkg::dim_t       out_best_r;
  nds_pkg::div_req_t   div_req;
  nds_pkg::div_rsp_t   div_rsp;
  nds_pkg::cmp_req_t   cmp_req;
  nds_pkg::cmp_rsp_t   cmp_rsp;
  logic                load_in;
  logic                load_out;
  logic                advance;
  logic                take_i;
  logic                take_q;

  nds_divider u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  nds_ratio_cmp u_ratio_cmp (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cmp_req),
    .rsp   (cmp_rsp)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      nds_pkg::ST_IDLE: begin
        if (in_chan.valid) state_nxt = nds_pkg::ST_CHECK;
      end
      nds_pkg::ST_CHECK: begin
        state_nxt = (isq_r <= nds_pkg::SQ_BITS'(size_r)) ? nds_pkg::ST_DIV
                                                         : nds_pkg::ST_FINISH;
      end
      nds_pkg::ST_DIV: state_nxt = nds_pkg::ST_WAIT_DIV;
      nds_pkg::ST_WAIT_DIV: begin
        if (div_rsp.done) begin
          state_nxt = div_rsp.rem_zero ? nds_pkg::ST_CMP_I : nds_pkg::ST_CHECK;
        end
      end
      nds_pkg::ST_CMP_I: state_nxt = nds_pkg::ST_WAIT_I;
      nds_pkg::ST_WAIT_I: begin
        if (cmp_rsp.done) state_nxt = nds_pkg::ST_CMP_Q;
      end
      nds_pkg::ST_CMP_Q: state_nxt = nds_pkg::ST_WAIT_Q;
      nds_pkg::ST_WAIT_Q: begin
        if (cmp_rsp.done) state_nxt = nds_pkg::ST_CHECK;
      end
      nds_pkg::ST_FINISH: begin
        if (!out_valid_r || out_chan.ready) state_nxt = nds_pkg::ST_IDLE;
      end
      default: state_nxt = nds_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_chan.ready    = (state_r == nds_pkg::ST_IDLE);
    load_in          = in_chan.ready && in_chan.valid;
    load_out         = (state_r == nds_pkg::ST_FINISH) && (!out_valid_r || out_chan.ready);
    advance          = ((state_r == nds_pkg::ST_WAIT_DIV) && div_rsp.done && !div_rsp.rem_zero)
                    || ((state_r == nds_pkg::ST_WAIT_Q) && cmp_rsp.done);
    take_i           = (state_r == nds_pkg::ST_WAIT_I) && cmp_rsp.done && cmp_rsp.closer;
    take_q           = (state_r == nds_pkg::ST_WAIT_Q) && cmp_rsp.done && cmp_rsp.closer;
    div_req.start    = (state_r == nds_pkg::ST_DIV);
    div_req.dividend = size_r;
    div_req.divisor  = i_r;
    cmp_req.start    = (state_r == nds_pkg::ST_CMP_I) || (state_r == nds_pkg::ST_CMP_Q);
    cmp_req.cand     = (state_r == nds_pkg::ST_CMP_I) ? nds_pkg::DIM_BITS'(i_r) : div_rsp.quot;
    cmp_req.best     = best_r;
    cmp_req.target   = target_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nds_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_in) begin
      size_r   <= in_chan.dim_size;
      target_r <= in_chan.target_size;
      best_r   <= in_chan.dim_size;
      i_r      <= nds_pkg::IDX_BITS'(1);
      isq_r    <= nds_pkg::SQ_BITS'(1);
    end else begin
      // Step to i+1; (i+1)^2 = i^2 + 2i + 1.
      if (advance) begin
        i_r   <= i_r + nds_pkg::IDX_BITS'(1);
        isq_r <= isq_r + nds_pkg::SQ_BITS'({i_r, 1'b1});
      end
      if (take_i) begin
        best_r <= nds_pkg::DIM_BITS'(i_r);
      end else if (take_q) begin
        best_r <= div_rsp.quot;
      end
    end
    if (load_out) out_best_r <= best_r;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.best_factor = out_best_r;

endmodule

// ----- design/nds_divider.sv -----
module nds_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  nds_pkg::div_req_t req,
  output nds_pkg::div_rsp_t rsp
);

  logic                       busy_r;
  logic                       done_r;
  nds_pkg::cnt_t              cnt_r;
  nds_pkg::dim_t              dvd_r;
  nds_pkg::dim_t              quo_r;
  nds_pkg::idx_t              rem_r;
  nds_pkg::idx_t              dvs_r;
  logic [nds_pkg::IDX_BITS:0] shifted;
  logic [nds_pkg::IDX_BITS:0] diff;
  logic                       ge;
  nds_pkg::idx_t              rem_nxt;

  // One restoring step: bring down the next dividend bit, subtract if it fits.
  always_comb begin
    shifted = {rem_r, dvd_r[nds_pkg::DIM_BITS-1]};
    diff    = shifted - {1'b0, dvs_r};
    ge      = shifted >= {1'b0, dvs_r};
    rem_nxt = ge ? diff[nds_pkg::IDX_BITS-1:0] : shifted[nds_pkg::IDX_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= nds_pkg::CNT_BITS'(nds_pkg::DIM_BITS);
    end else if (busy_r) begin
      cnt_r <= cnt_r - nds_pkg::CNT_BITS'(1);
      if (cnt_r == nds_pkg::CNT_BITS'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dvs_r <= req.divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[nds_pkg::DIM_BITS-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[nds_pkg::DIM_BITS-2:0], ge};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quot     = quo_r;
  assign rsp.rem_zero = (rem_r == '0);

endmodule

// ----- design/nds_ratio_cmp.sv -----
module nds_ratio_cmp (
  input  logic              clk,
  input  logic              rst_n,
  input  nds_pkg::cmp_req_t req,
  output nds_pkg::cmp_rsp_t rsp
);

  nds_pkg::cmp_phase_t phase_r;
  nds_pkg::cmp_phase_t phase_nxt;
  nds_pkg::dim_t       amax_r;
  nds_pkg::dim_t       amin_r;
  nds_pkg::dim_t       bmax_r;
  nds_pkg::dim_t       bmin_r;
  nds_pkg::prod_t      lhs_r;
  nds_pkg::prod_t      rhs_r;
  nds_pkg::dim_t       op_a;
  nds_pkg::dim_t       op_b;
  nds_pkg::prod_t      prod;

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      nds_pkg::CMP_IDLE: if (req.start) phase_nxt = nds_pkg::CMP_LHS;
      nds_pkg::CMP_LHS:  phase_nxt = nds_pkg::CMP_RHS;
      nds_pkg::CMP_RHS:  phase_nxt = nds_pkg::CMP_DONE;
      nds_pkg::CMP_DONE: phase_nxt = nds_pkg::CMP_IDLE;
      default:           phase_nxt = nds_pkg::CMP_IDLE;
    endcase
  end

  // Shared multiplier: max(a,t)*min(b,t) first, then max(b,t)*min(a,t).
  always_comb begin
    op_a       = (phase_r == nds_pkg::CMP_LHS) ? amax_r : bmax_r;
    op_b       = (phase_r == nds_pkg::CMP_LHS) ? bmin_r : amin_r;
    prod       = nds_pkg::PROD_BITS'(op_a) * nds_pkg::PROD_BITS'(op_b);
    rsp.done   = (phase_r == nds_pkg::CMP_DONE);
    rsp.closer = (lhs_r < rhs_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= nds_pkg::CMP_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (phase_r == nds_pkg::CMP_IDLE && req.start) begin
      amax_r <= (req.cand > req.target) ? req.cand   : req.target;
      amin_r <= (req.cand > req.target) ? req.target : req.cand;
      bmax_r <= (req.best > req.target) ? req.best   : req.target;
      bmin_r <= (req.best > req.target) ? req.target : req.best;
    end
    if (phase_r == nds_pkg::CMP_LHS) lhs_r <= prod;
    if (phase_r == nds_pkg::CMP_RHS) rhs_r <= prod;
  end

endmodule

// ----- design/nds_checker.sv -----
module nds_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [nds_pkg::DIM_BITS-1:0] best_factor
);

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("block not idle after reset");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(best_factor))
    else $error("result changed while stalled");

endmodule

bind nearest_divisor_log_ratio nds_checker u_nds_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .best_factor (out_chan.best_factor)
);

// ----- sim/nearest_divisor_log_ratio_test.sv -----
`timescale 1ns / 1ps

module nearest_divisor_log_ratio_test;

  // Longest item runs through about 4096 trial divisors; the hang limit is set well above its run time.
  localparam int unsigned IDLE_LIMIT = 500000;
  localparam int unsigned RANDOM_ITEMS = 100;
  localparam int unsigned DRAIN_CYCLES = 64;

  class factor_scoreboard;
    nds_pkg::dim_t pending[$];
    int unsigned   requests;
    int unsigned   checked;
    int unsigned   errors;

    function automatic bit strictly_closer(longint unsigned a, longint unsigned b,
                                           longint unsigned t);
      longint unsigned amax, amin, bmax, bmin;
      amax = (a > t) ? a : t;
      amin = (a > t) ? t : a;
      bmax = (b > t) ? b : t;
      bmin = (b > t) ? t : b;
      // Products stay within 48 bits, so 64-bit math is exact.
      return (amax * bmin) < (bmax * amin);
    endfunction

    function automatic nds_pkg::dim_t nearest_factor(nds_pkg::dim_t size,
                                                     nds_pkg::dim_t target);
      longint unsigned s, t, best, i, q;
      s    = size;
      t    = target;
      best = s;
      for (i = 1; i * i <= s; i++) begin
        if (s % i == 0) begin
          q = s / i;
          if (strictly_closer(i, best, t)) best = i;
          if (strictly_closer(q, best, t)) best = q;
        end
      end
      return nds_pkg::dim_t'(best);
    endfunction

    function void note_request(nds_pkg::dim_t size, nds_pkg::dim_t target);
      pending.insert(pending.size(), nearest_factor(size, target));
      requests++;
    endfunction

    function void check_factor(nds_pkg::dim_t got);
      nds_pkg::dim_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected best_factor %0d with no request outstanding", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got !== want) begin
        $display("%0t: best_factor mismatch: expected %0d, actual %0d", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  nds_in_if  in_chan();
  nds_out_if out_chan();

  nearest_divisor_log_ratio dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  factor_scoreboard sb = new();
  int unsigned      idle_cycles;
  int unsigned      burst_left;
  nds_pkg::dim_t    widest_extent;

  // Monitor both channels and watch for a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) begin
        sb.note_request(in_chan.dim_size, in_chan.target_size);
        if (in_chan.dim_size > widest_extent) widest_extent = in_chan.dim_size;
      end
      if (out_chan.valid && out_chan.ready) sb.check_factor(out_chan.best_factor);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Receiver: pick a stall pattern at random, switching to a new one periodically.
  int unsigned stall_mode;
  int unsigned stall_count;
  always @(posedge clk) begin
    stall_count++;
    if (stall_count % 256 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: begin
        out_chan.ready <= 1'b1;
      end
      1: begin
        out_chan.ready <= $urandom_range(0, 1);
      end
      2: begin
        out_chan.ready <= (stall_count % 8 == 0);
      end
      default: begin
        // Long hold-off so the next request gets taken while a result waits.
        out_chan.ready <= (stall_count % 97 == 0);
      end
    endcase
  end

  task automatic issue_request(nds_pkg::dim_t size, nds_pkg::dim_t target);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      if (gap != 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    in_chan.valid       <= 1'b1;
    in_chan.dim_size    <= size;
    in_chan.target_size <= target;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  function automatic nds_pkg::dim_t random_extent();
    int unsigned   pick, w, k;
    nds_pkg::dim_t v;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      k = $urandom_range(1, 64);
      v = nds_pkg::dim_t'(k * k);
    end else if (pick < 80) begin
      w = $urandom_range(1, 12);
      v = nds_pkg::dim_t'($urandom & ((32'd1 << w) - 1));
    end else if (pick < 97) begin
      w = $urandom_range(13, 18);
      v = nds_pkg::dim_t'($urandom & ((32'd1 << w) - 1));
    end else begin
      v = nds_pkg::dim_t'($urandom);
    end
    return v;
  endfunction

  function automatic nds_pkg::dim_t random_target();
    int unsigned pick, w;
    pick = $urandom_range(0, 99);
    if (pick < 5) return '0;
    if (pick < 10) return nds_pkg::dim_t'($urandom) | nds_pkg::dim_t'(24'h800000);
    if (pick < 40) return nds_pkg::dim_t'($urandom_range(1, 64));
    w = $urandom_range(1, 24);
    return nds_pkg::dim_t'($urandom & ((32'd1 << w) - 1));
  endfunction

  initial begin
    rst_n               = 1'b0;
    in_chan.valid       = 1'b0;
    in_chan.dim_size    = '0;
    in_chan.target_size = '0;
    out_chan.ready      = 1'b0;
    idle_cycles         = 0;
    burst_left          = 0;
    widest_extent       = '0;
    stall_mode          = 0;
    stall_count         = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero extent, zero target, unit and prime extents, squares,
    // targets above the extent and the widest extent.
    issue_request(24'd0, 24'd5);
    issue_request(24'd0, 24'd0);
    issue_request(24'd1, 24'd1);
    issue_request(24'd1, 24'hFFFFFF);
    issue_request(24'd7, 24'd0);
    issue_request(24'd5, 24'd3);
    issue_request(24'd36, 24'd6);
    issue_request(24'd36, 24'd5);
    issue_request(24'd36, 24'd7);
    issue_request(24'd8, 24'd4);
    issue_request(24'd97, 24'd10);
    issue_request(24'd12, 24'hFFFFFF);
    issue_request(24'd1024, 24'h800000);
    issue_request(24'd4096, 24'd3);
    issue_request(24'd65535, 24'd300);
    issue_request(24'hFFFFFF, 24'h001001);

    repeat (RANDOM_ITEMS) issue_request(random_extent(), random_target());
    in_chan.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    // Catch any stray extra result.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests (directed edge cases plus random extents up to %0d),",
             sb.requests, widest_extent);
    $display("%0d factors checked against the predicted divisor, %0d mismatches.",
             sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
